/* design/spe_pkg.sv */
package spe_pkg;

  localparam int STORE_DEPTH_DEF = 64;
  localparam int VAL_W = 32;
  localparam int PCT_W = 17;
  localparam int FRAC_BITS = 16;
  localparam logic [PCT_W-1:0] PCT_ONE = 17'h10000;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_QUERY  = 1'b1
  } command_t;

  typedef struct packed {
    command_t                 command;
    logic signed [VAL_W-1:0]  sample_value;
    logic [PCT_W-1:0]         percent;
  } request_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  estimate;
    logic [VAL_W-1:0]         samples_seen;
  } result_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_I_SW,
    S_C_RD0,
    S_C_RD1,
    S_C_WR,
    S_I_PREP,
    S_I_INS,
    S_I_CMP,
    S_I_DONE,
    S_Q_INIT,
    S_Q_ONE,
    S_Q_SIDE,
    S_Q_T,
    S_Q_LO,
    S_Q_HI,
    S_Q_FR,
    S_Q_RN,
    S_Q_ACC,
    S_Q_DIV,
    S_Q_WAIT
  } state_t;

endpackage

/* design/spe_ram.sv */
module spe_ram
  import spe_pkg::*;
#(
  parameter int WIDTH = VAL_W,
  parameter int DEPTH = STORE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/spe_div.sv */
module spe_div
  import spe_pkg::*;
#(
  parameter int NUM_W = 44,
  parameter int DEN_W = 12
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic [NUM_W-1:0] quotient,
  output logic             done
);

  localparam int CNT_W = $clog2(NUM_W + 1);

  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic             run;
  logic [DEN_W:0]   trial;
  logic             fits;

  // restoring step, one quotient bit a cycle
  assign trial = {rem, quotient[NUM_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run      <= 1'b1;
        cnt      <= CNT_W'(NUM_W);
        rem      <= '0;
        dsr      <= divisor;
        quotient <= dividend;
      end else if (run) begin
        rem      <= fits ? DEN_W'(trial - {1'b0, dsr}) : DEN_W'(trial);
        quotient <= {quotient[NUM_W-2:0], fits};
        cnt      <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* design/streaming_percentile_estimator.sv */
// Streaming percentile estimator. Pulse start with a request word while busy
// is low: an insert places the sample in sorted order into the active store
// of STORE_DEPTH entries and gives no result; a query returns one result word
// on result, marked by done for exactly one cycle, and it must be taken then
// since the receiver cannot stall. One shared sequencer steps through the
// store memories one access at a time: an insert that finds the active store
// full switches to the other store and, after the first switch, compacts it
// into averaged pairs; a query feeds its weighted mean to the serial divider,
// whose dividend has 33+clog2(STORE_DEPTH+1) bits.
module streaming_percentile_estimator
  import spe_pkg::*;
#(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  request_t request,
  output logic     busy,
  output result_t  result,
  output logic     done
);

  localparam int AW    = $clog2(STORE_DEPTH);
  localparam int FW    = $clog2(STORE_DEPTH + 1);
  localparam int NUM_W = VAL_W + FW + 1;
  localparam int DEN_W = FW + 1;
  localparam int MA_W  = VAL_W + 2;
  localparam int MB_W  = (FW + 1 > PCT_W) ? FW + 1 : PCT_W;
  localparam int PW    = MA_W + MB_W;
  localparam logic [FW-1:0] DEPTH_F = FW'(STORE_DEPTH);

  state_t state, state_next;

  logic [FW-1:0]           fill_even, fill_odd;
  logic                    side_active, compaction_on, ws;
  logic [VAL_W-1:0]        total_samples;
  logic signed [VAL_W-1:0] v, lo, r;
  logic [PCT_W-1:0]        pct;
  logic [FW-1:0]           j, ci, half, idx;
  logic [FRAC_BITS-1:0]    frac;
  logic                    last;
  logic signed [NUM_W-1:0] num;
  logic signed [PW-1:0]    prod;

  logic signed [MA_W-1:0]  mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic [FW-1:0]           fill_ws, fill_cur, fill_oth, t_idx;
  logic                    t_last;
  logic [AW-1:0]           raddr, waddr;
  logic [VAL_W-1:0]        wdata, rd_even, rd_odd;
  logic signed [VAL_W-1:0] rdata;
  logic                    we;
  logic                    div_start, div_done;
  logic [NUM_W-1:0]        div_q, num_mag;
  logic [VAL_W:0]          pair_sum;

  assign fill_ws  = ws ? fill_odd : fill_even;
  assign fill_cur = side_active ? fill_odd : fill_even;
  assign fill_oth = side_active ? fill_even : fill_odd;
  assign rdata    = ws ? $signed(rd_odd) : $signed(rd_even);
  assign t_idx    = prod[FRAC_BITS +: FW];
  assign t_last   = ({1'b0, t_idx} + 1'b1) >= {1'b0, fill_ws};
  assign pair_sum = {lo[VAL_W-1], lo} + {rdata[VAL_W-1], rdata};
  assign num_mag  = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign busy     = state != S_IDLE;

  // store memories
  spe_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) u_ram_even (
    .clk(clk), .we(we && !ws), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rd_even)
  );

  spe_ram #(.WIDTH(VAL_W), .DEPTH(STORE_DEPTH)) u_ram_odd (
    .clk(clk), .we(we && ws), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rd_odd)
  );

  // serial divider for the weighted mean
  spe_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .dividend(num_mag), .divisor(DEN_W'(fill_even) + DEN_W'(fill_odd)),
    .quotient(div_q), .done(div_done)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (start) begin
                  state_next = (request.command == CMD_INSERT) ? S_I_SW : S_Q_INIT;
                end
      S_I_SW:   state_next = (fill_cur >= DEPTH_F && compaction_on) ? S_C_RD0 : S_I_PREP;
      S_C_RD0:  state_next = (ci == half) ? S_I_PREP : S_C_RD1;
      S_C_RD1:  state_next = S_C_WR;
      S_C_WR:   state_next = S_C_RD0;
      S_I_PREP: state_next = S_I_INS;
      S_I_INS:  state_next = (j == '0) ? S_I_DONE : S_I_CMP;
      S_I_CMP:  state_next = (rdata > v) ? S_I_INS : S_I_DONE;
      S_I_DONE: state_next = S_IDLE;
      S_Q_INIT: begin
                  if (total_samples == '0) begin
                    state_next = S_IDLE;
                  end else if (total_samples == VAL_W'(1)) begin
                    state_next = S_Q_ONE;
                  end else begin
                    state_next = S_Q_SIDE;
                  end
                end
      S_Q_ONE:  state_next = S_IDLE;
      S_Q_SIDE: begin
                  if (fill_ws != '0) begin
                    state_next = S_Q_T;
                  end else if (ws) begin
                    state_next = S_Q_DIV;
                  end
                end
      S_Q_T:    state_next = S_Q_LO;
      S_Q_LO:   state_next = last ? S_Q_RN : S_Q_HI;
      S_Q_HI:   state_next = S_Q_FR;
      S_Q_FR:   state_next = S_Q_RN;
      S_Q_RN:   state_next = S_Q_ACC;
      S_Q_ACC:  state_next = ws ? S_Q_DIV : S_Q_SIDE;
      S_Q_DIV:  state_next = S_Q_WAIT;
      S_Q_WAIT: if (div_done) begin
                  state_next = S_IDLE;
                end
      default:  state_next = S_IDLE;
    endcase
  end

  // memory, multiplier and divider controls
  always_comb begin
    raddr     = '0;
    waddr     = '0;
    wdata     = v;
    we        = 1'b0;
    mul_a     = MA_W'($signed({1'b0, pct}));
    mul_b     = MB_W'($signed({1'b0, fill_ws}));
    div_start = 1'b0;
    unique case (state)
      S_C_RD0:  raddr = AW'({ci, 1'b0});
      S_C_RD1:  raddr = AW'({ci, 1'b1});
      S_C_WR:   begin
                  we    = 1'b1;
                  waddr = AW'(ci);
                  wdata = pair_sum[VAL_W:1];
                end
      S_I_INS:  begin
                  raddr = AW'(j - 1'b1);
                  if (j == '0) begin
                    we    = 1'b1;
                    waddr = '0;
                  end
                end
      S_I_CMP:  begin
                  we    = 1'b1;
                  waddr = AW'(j);
                  wdata = (rdata > v) ? rdata : v;
                end
      S_Q_T:    raddr = t_last ? AW'(fill_ws - 1'b1) : AW'(t_idx);
      S_Q_LO:   raddr = AW'(idx + 1'b1);
      S_Q_HI:   begin
                  mul_a = MA_W'(rdata) - MA_W'(lo);
                  mul_b = MB_W'($signed({1'b0, frac}));
                end
      S_Q_RN:   mul_a = MA_W'(r);
      S_Q_DIV:  div_start = 1'b1;
      default:  ;
    endcase
  end

  // shared product register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      fill_even     <= '0;
      fill_odd      <= '0;
      side_active   <= 1'b0;
      compaction_on <= 1'b0;
      total_samples <= '0;
      done          <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        S_I_SW:   if (fill_cur >= DEPTH_F) begin
                    side_active   <= !side_active;
                    compaction_on <= 1'b1;
                  end
        S_C_RD0:  if (ci == half) begin
                    if (ws) fill_odd <= half;
                    else    fill_even <= half;
                  end
        S_I_PREP: if (fill_ws >= DEPTH_F) begin
                    if (ws) fill_odd <= DEPTH_F - 1'b1;
                    else    fill_even <= DEPTH_F - 1'b1;
                  end
        S_I_DONE: begin
                    if (ws) fill_odd <= fill_odd + 1'b1;
                    else    fill_even <= fill_even + 1'b1;
                    if (total_samples != '1) total_samples <= total_samples + 1'b1;
                  end
        S_Q_INIT: if (total_samples == '0) done <= 1'b1;
        S_Q_ONE:  done <= 1'b1;
        S_Q_WAIT: if (div_done) done <= 1'b1;
        default:  ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE:   begin
                  v   <= request.sample_value;
                  pct <= (request.percent > PCT_ONE) ? PCT_ONE : request.percent;
                end
      S_I_SW:   begin
                  ws   <= (fill_cur >= DEPTH_F) ? !side_active : side_active;
                  half <= fill_oth >> 1;
                  ci   <= '0;
                end
      S_C_RD1:  lo <= rdata;
      S_C_WR:   ci <= ci + 1'b1;
      S_I_PREP: j <= (fill_ws >= DEPTH_F) ? DEPTH_F - 1'b1 : fill_ws;
      S_I_CMP:  if (rdata > v) j <= j - 1'b1;
      S_Q_INIT: begin
                  ws  <= 1'b0;
                  num <= '0;
                  result.samples_seen <= total_samples;
                  result.estimate     <= '0;
                end
      S_Q_ONE:  result.estimate <= rdata;
      S_Q_SIDE: if (fill_ws == '0 && !ws) ws <= 1'b1;
      S_Q_T:    begin
                  idx  <= t_idx;
                  frac <= prod[FRAC_BITS-1:0];
                  last <= t_last;
                end
      S_Q_LO:   begin
                  lo <= rdata;
                  r  <= rdata;
                end
      S_Q_FR:   r <= lo + VAL_W'(prod >>> FRAC_BITS);
      S_Q_ACC:  begin
                  num <= num + NUM_W'(prod);
                  ws  <= 1'b1;
                end
      S_Q_WAIT: result.estimate <= num[NUM_W-1] ? -$signed(div_q[VAL_W-1:0])
                                                : $signed(div_q[VAL_W-1:0]);
      default:  ;
    endcase
  end

  // checks
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while sequencer busy");
  a_fill_even: assert property (@(posedge clk) disable iff (rst) fill_even <= DEPTH_F)
    else $error("even fill beyond depth");
  a_fill_odd: assert property (@(posedge clk) disable iff (rst) fill_odd <= DEPTH_F)
    else $error("odd fill beyond depth");
  a_div_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> (DEN_W'(fill_even) + DEN_W'(fill_odd)) != '0)
    else $error("division by empty stores");

endmodule
